>>> rtl/bvt_pkg.sv
// Shared types and constants for the bounded vector table.
// No dependencies; every other file imports this package.
`default_nettype none

package bvt_pkg;

	// Fixed widths of the request and response fields.
	localparam int OP_W      = 3;
	localparam int POS_W     = 7;
	localparam int ITEM_W    = 32;
	localparam int RD_W      = 32;
	localparam int CNT_OUT_W = 7;
	localparam int ST_W      = 2;

	// Defaults for the top-level parameters.
	localparam int DEPTH_DEF       = 64;
	localparam int VALUE_WIDTH_DEF = 32;

	// Request operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_READ        = 3'd0,
		OP_INSERT      = 3'd1,
		OP_ERASE       = 3'd2,
		OP_ERASE_RANGE = 3'd3,
		OP_APPEND      = 3'd4,
		OP_CLEAR       = 3'd5
	} op_t;

	// Response status codes.
	typedef enum logic [ST_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_RDWAIT,
		S_MOVE,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

>>> rtl/bvt_req_if.sv
// Request channel of the bounded vector table: valid/ready plus the request word.
// Depends on bvt_pkg for the field widths.
`default_nettype none

interface bvt_req_if
	import bvt_pkg::*;
	();

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [POS_W-1:0]  position;
	logic [POS_W-1:0]  range_end;
	logic [ITEM_W-1:0] item_value;

	modport source (output valid, operation, position, range_end, item_value, input ready);
	modport sink   (input valid, operation, position, range_end, item_value, output ready);

endinterface

`default_nettype wire

>>> rtl/bvt_rsp_if.sv
// Response channel of the bounded vector table: valid/ready plus the result word.
// Depends on bvt_pkg for the field widths.
`default_nettype none

interface bvt_rsp_if
	import bvt_pkg::*;
	();

	logic                 valid;
	logic                 ready;
	logic [RD_W-1:0]      read_value;
	logic [CNT_OUT_W-1:0] element_count;
	logic                 is_empty;
	logic [ST_W-1:0]      status;

	modport source (output valid, read_value, element_count, is_empty, status, input ready);
	modport sink   (input valid, read_value, element_count, is_empty, status, output ready);

endinterface

`default_nettype wire

>>> rtl/bounded_vector_table.sv
// Bounded vector table: an ordered array of up to DEPTH values with read, insert,
// erase, range erase, append and clear. Depends on bvt_pkg, bvt_req_if, bvt_rsp_if.
//
// Each request word yields exactly one response word carrying the value read (zero
// unless a successful read), the element count after the request, an empty flag and
// a status (ok, full, or bad index/range); a rejected request leaves the table
// untouched. The entries live in a single-port-write, registered-read memory, and a
// small sequencer moves one entry per cycle through it, so the cost of a request is
// set by how many entries must shift: k entries move for an insert, erase or range
// erase (k is count minus position for insert, count minus position minus one for
// erase, count minus range end for a range erase), and none for a read, append,
// clear or rejected request. The request channel is ready only while the sequencer
// is idle, so a new request is not taken before the last one has finished. A
// finished response waits in an output register, so the next request can be taken
// before the response is collected.
`default_nettype none

module bounded_vector_table
	import bvt_pkg::*;
#(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bvt_req_if.sink    req,
	bvt_rsp_if.source  rsp
);

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;
	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

	// Control state.
	state_t          state_q, state_d;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   left_q;
	logic            pend_q;
	logic            rsp_valid_q;

	// Working registers of the current request.
	logic [AW-1:0]          src_q, dst_q, fin_addr_q;
	logic                   down_q, fin_q;
	logic [VALUE_WIDTH-1:0] val_q, res_rd_q, rd_data_q;
	status_t                res_st_q;

	// Output registers.
	logic [RD_W-1:0]      out_rd_q;
	logic [CNT_OUT_W-1:0] out_cnt_q;
	logic                 out_empty_q;
	status_t              out_st_q;

	// Entry memory.
	logic [VALUE_WIDTH-1:0] entry_store_q [DEPTH];
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr, mem_raddr;
	logic [VALUE_WIDTH-1:0] mem_wdata;

	// Request decode results.
	op_t                    op;
	logic [CMP_W-1:0]       pos_c, end_c, cnt_c;
	logic [63:0]            item_ext, rd_ext;
	logic [VALUE_WIDTH-1:0] item_val;
	status_t                dec_st;
	logic [CMP_W-1:0]       dec_count, dec_left, dec_src, dec_dst, dec_fin_addr;
	logic                   dec_down, dec_fin, dec_read;

	// Sequencer strobes.
	logic acc, issue_rd, load_out;

	assign op       = op_t'(req.operation);
	assign pos_c    = CMP_W'(req.position);
	assign end_c    = CMP_W'(req.range_end);
	assign cnt_c    = CMP_W'(count_q);
	assign item_ext = 64'(req.item_value);
	assign item_val = item_ext[VALUE_WIDTH-1:0];
	assign acc      = req.valid && req.ready;

	// Check the request against the current count and work out the shift plan.
	always_comb begin
		dec_st       = ST_OK;
		dec_count    = cnt_c;
		dec_left     = '0;
		dec_src      = '0;
		dec_dst      = '0;
		dec_down     = 1'b0;
		dec_fin      = 1'b0;
		dec_fin_addr = '0;
		dec_read     = 1'b0;
		unique case (op)
			OP_READ: begin
				if (pos_c < cnt_c) begin
					dec_read = 1'b1;
				end else begin
					dec_st = ST_BAD;
				end
			end
			OP_INSERT: begin
				if (pos_c > cnt_c) begin
					dec_st = ST_BAD;
				end else if (cnt_c == DEPTH_C) begin
					dec_st = ST_FULL;
				end else begin
					dec_left     = cnt_c - pos_c;
					dec_src      = cnt_c - 1'b1;
					dec_dst      = cnt_c;
					dec_down     = 1'b1;
					dec_fin      = 1'b1;
					dec_fin_addr = pos_c;
					dec_count    = cnt_c + 1'b1;
				end
			end
			OP_ERASE: begin
				if (pos_c >= cnt_c) begin
					dec_st = ST_BAD;
				end else begin
					dec_left  = cnt_c - pos_c - 1'b1;
					dec_src   = pos_c + 1'b1;
					dec_dst   = pos_c;
					dec_count = cnt_c - 1'b1;
				end
			end
			OP_ERASE_RANGE: begin
				if ((pos_c > end_c) || (end_c > cnt_c)) begin
					dec_st = ST_BAD;
				end else begin
					dec_left  = cnt_c - end_c;
					dec_src   = end_c;
					dec_dst   = pos_c;
					dec_count = cnt_c - (end_c - pos_c);
				end
			end
			OP_APPEND: begin
				if (cnt_c == DEPTH_C) begin
					dec_st = ST_FULL;
				end else begin
					dec_fin      = 1'b1;
					dec_fin_addr = cnt_c;
					dec_count    = cnt_c + 1'b1;
				end
			end
			OP_CLEAR: begin
				dec_count = '0;
			end
			default: begin
				dec_st = ST_BAD;
			end
		endcase
	end

	// Next state, handshake and memory port control.
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = dst_q;
		mem_wdata = rd_data_q;
		mem_raddr = src_q;
		issue_rd  = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				mem_raddr = pos_c[AW-1:0];
				if (req.valid) begin
					state_d = dec_read ? S_RDWAIT : S_MOVE;
				end
			end
			S_RDWAIT: begin
				state_d = S_DONE;
			end
			S_MOVE: begin
				// Read the next source entry while writing the one read last cycle.
				issue_rd = (left_q != '0);
				if (pend_q) begin
					mem_we = 1'b1;
				end else if (left_q == '0) begin
					mem_we    = fin_q;
					mem_waddr = fin_addr_q;
					mem_wdata = val_q;
					state_d   = S_DONE;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Count, shift counter and valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			left_q      <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q <= dec_count[CW-1:0];
				left_q  <= dec_left[CW-1:0];
			end else if (issue_rd) begin
				left_q <= left_q - 1'b1;
			end
			pend_q <= issue_rd;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Addresses, carried value and result fields.
	always_ff @(posedge clk) begin
		if (acc) begin
			src_q      <= dec_src[AW-1:0];
			dst_q      <= dec_dst[AW-1:0];
			down_q     <= dec_down;
			fin_q      <= dec_fin;
			fin_addr_q <= dec_fin_addr[AW-1:0];
			val_q      <= item_val;
			res_st_q   <= dec_st;
			res_rd_q   <= '0;
		end else begin
			if (issue_rd) begin
				src_q <= down_q ? src_q - 1'b1 : src_q + 1'b1;
			end
			if (pend_q) begin
				dst_q <= down_q ? dst_q - 1'b1 : dst_q + 1'b1;
			end
			if (state_q == S_RDWAIT) begin
				res_rd_q <= rd_data_q;
			end
		end
	end

	assign rd_ext = 64'(res_rd_q);

	// Output register; it is reloaded only once the previous word has gone.
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_rd_q    <= rd_ext[RD_W-1:0];
			out_cnt_q   <= cnt_c[CNT_OUT_W-1:0];
			out_empty_q <= (count_q == '0);
			out_st_q    <= res_st_q;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.read_value    = out_rd_q;
	assign rsp.element_count = out_cnt_q;
	assign rsp.is_empty      = out_empty_q;
	assign rsp.status        = out_st_q;

	// Entry memory with one write port and a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_store_q[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= entry_store_q[mem_raddr];
	end

	// The count never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above capacity");

	// The count changes only when a request word is taken.
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.valid && req.ready) |=> $stable(count_q))
		else $error("entry count changed without a request");

	// Every memory write lands below the updated count.
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CW'(mem_waddr) < count_q))
		else $error("memory write beyond the stored entries");

	// A pending shift write only exists while the sequencer is moving entries.
	a_pend_in_move: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q == S_MOVE))
		else $error("shift write pending outside the move phase");

endmodule

`default_nettype wire
